[sv/aarm_pkg.sv]
// ----------------------------------------------------------------------------
// aarm_pkg: shared types, constants and functions
// Shared by the axis-angle rotation matrix unit: CORDIC arctangent table,
// gain constant, beat payload types and the rounding and saturation helpers.
// ----------------------------------------------------------------------------
package aarm_pkg;

  localparam int AtanEntries = 24;
  localparam int CordW = 34;          // Q2.30 plus growth headroom
  localparam int AngW  = 33;          // residual angle, 2^32 per turn plus sign

  localparam logic signed [CordW-1:0] CordicGain = 34'sd652032874;

  typedef struct packed {
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic [15:0]        turn_angle;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
  } out_beat_t;

  // State carried along the cell chain beside the CORDIC vector.
  typedef struct packed {
    logic               flip;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
  } side_t;

  // Arctangent of 2^-i as a 32-bit binary angle, truncated.
  function automatic logic signed [AngW-1:0] atan_turns(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051D;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2E;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2F9;
      5'd15: v = 32'h0000517C;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A2F;
      5'd19: v = 32'h00000517;
      5'd20: v = 32'h0000028B;
      5'd21: v = 32'h00000145;
      5'd22: v = 32'h000000A2;
      5'd23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return $signed({1'b0, v});
  endfunction

  // Round Q30 to Q14 (half up) and clamp to plus or minus one.
  function automatic logic signed [15:0] to_q14(input logic signed [CordW-1:0] v);
    logic signed [CordW-1:0] r;
    r = (v + 34'sd32768) >>> 16;
    if (r > 34'sd16384)       return 16'sd16384;
    else if (r < -34'sd16384) return -16'sd16384;
    else                      return r[15:0];
  endfunction

  // Round Q42 to Q14 (half up) and saturate.
  function automatic logic signed [15:0] finish(input logic signed [47:0] q);
    logic signed [47:0] r;
    r = (q + 48'sd134217728) >>> 28;
    if (r > 48'sd32767)       return 16'sh7FFF;
    else if (r < -48'sd32768) return 16'sh8000;
    else                      return r[15:0];
  endfunction

endpackage

[sv/aarm_stream_if.sv]
// ----------------------------------------------------------------------------
// aarm_stream_if: valid/ready channel
// Carries one beat of a given payload type between a source and a sink.
// ----------------------------------------------------------------------------
interface aarm_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[sv/aarm_cordic_cell.sv]
// ----------------------------------------------------------------------------
// aarm_cordic_cell: one CORDIC micro-rotation
// Rotates the vector by the arctangent of 2^-STEP and registers the result,
// carrying valid and the side data to the next cell.
// ----------------------------------------------------------------------------
module aarm_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic signed [aarm_pkg::CordW-1:0]   in_x,
  input  logic signed [aarm_pkg::CordW-1:0]   in_y,
  input  logic signed [aarm_pkg::AngW-1:0]    in_z,
  input  aarm_pkg::side_t                     in_side,
  output logic                                out_valid,
  output logic signed [aarm_pkg::CordW-1:0]   x,
  output logic signed [aarm_pkg::CordW-1:0]   y,
  output logic signed [aarm_pkg::AngW-1:0]    z,
  output aarm_pkg::side_t                     side
);

  localparam logic [4:0] StepIdx = 5'(STEP);

  logic signed [aarm_pkg::CordW-1:0] x_next, y_next;
  logic signed [aarm_pkg::AngW-1:0]  z_next;

  // Pick the rotation direction from the sign of the residual angle
  always_comb begin
    if (!in_z[aarm_pkg::AngW-1]) begin
      x_next = in_x - (in_y >>> STEP);
      y_next = in_y + (in_x >>> STEP);
      z_next = in_z - aarm_pkg::atan_turns(StepIdx);
    end else begin
      x_next = in_x + (in_y >>> STEP);
      y_next = in_y - (in_x >>> STEP);
      z_next = in_z + aarm_pkg::atan_turns(StepIdx);
    end
  end

  // Advance when the chain is not stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      x    <= x_next;
      y    <= y_next;
      z    <= z_next;
      side <= in_side;
    end
  end

endmodule

[sv/aarm_matrix_stage.sv]
// ----------------------------------------------------------------------------
// aarm_matrix_stage: Rodrigues matrix assembly
// Three registered stages: sine/cosine rounding and axis products, then
// the Q42 terms, then rounding and saturation of the nine entries.
// ----------------------------------------------------------------------------
module aarm_matrix_stage (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic signed [aarm_pkg::CordW-1:0]  in_x,
  input  logic signed [aarm_pkg::CordW-1:0]  in_y,
  input  aarm_pkg::side_t                    in_side,
  output logic                               out_valid,
  output aarm_pkg::out_beat_t                result
);

  logic [1:0] vld;

  // Stage A: cos, sin, axis products
  logic signed [15:0] c_a, s_a;
  logic signed [31:0] xx, yy, zz, xy, xz, yz;
  logic signed [15:0] ax_a, ay_a, az_a;

  // Stage B: Q42 terms
  logic signed [47:0] t_xx, t_yy, t_zz, t_xy, t_xz, t_yz, t_xs, t_ys, t_zs, t_c;

  logic signed [aarm_pkg::CordW-1:0] xf, yf;
  logic signed [16:0] omc;

  // Undo the half-turn fold
  always_comb begin
    xf = in_side.flip ? -in_x : in_x;
    yf = in_side.flip ? -in_y : in_y;
    omc = 17'sd16384 - 17'(c_a);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[0], in_valid};
      out_valid <= vld[1];
    end
    if (en) begin
      c_a  <= aarm_pkg::to_q14(xf);
      s_a  <= aarm_pkg::to_q14(yf);
      xx   <= in_side.ax * in_side.ax;
      yy   <= in_side.ay * in_side.ay;
      zz   <= in_side.az * in_side.az;
      xy   <= in_side.ax * in_side.ay;
      xz   <= in_side.ax * in_side.az;
      yz   <= in_side.ay * in_side.az;
      ax_a <= in_side.ax;
      ay_a <= in_side.ay;
      az_a <= in_side.az;

      t_xx <= 48'(xx * omc);
      t_yy <= 48'(yy * omc);
      t_zz <= 48'(zz * omc);
      t_xy <= 48'(xy * omc);
      t_xz <= 48'(xz * omc);
      t_yz <= 48'(yz * omc);
      t_xs <= 48'(ax_a * s_a) <<< 14;
      t_ys <= 48'(ay_a * s_a) <<< 14;
      t_zs <= 48'(az_a * s_a) <<< 14;
      t_c  <= 48'(c_a) <<< 28;

      result.m00 <= aarm_pkg::finish(t_xx + t_c);
      result.m01 <= aarm_pkg::finish(t_xy - t_zs);
      result.m02 <= aarm_pkg::finish(t_xz + t_ys);
      result.m10 <= aarm_pkg::finish(t_xy + t_zs);
      result.m11 <= aarm_pkg::finish(t_yy + t_c);
      result.m12 <= aarm_pkg::finish(t_yz - t_xs);
      result.m20 <= aarm_pkg::finish(t_xz - t_ys);
      result.m21 <= aarm_pkg::finish(t_yz + t_xs);
      result.m22 <= aarm_pkg::finish(t_zz + t_c);
    end
  end

endmodule

[sv/axis_angle_rotation_matrix_unit.sv]
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix_unit: axis-angle to rotation matrix
// Takes one axis/angle beat per cycle while the output is not stalled and returns the Rodrigues matrix.
// ----------------------------------------------------------------------------
// Accepts one beat every cycle while the output is not stalled. The chain
// has one fold register, one cell per CORDIC step and three matrix stages.
// The whole pipeline advances together and holds while a result waits at
// the output, and since the output register is the last stage, a new beat
// is taken in the same cycle the waiting result leaves. Axes are used as given.
module axis_angle_rotation_matrix_unit #(
  parameter int SINCOS_STEPS = 16
) (
  input  logic clk,
  input  logic rst,
  aarm_stream_if.sink   s_in,
  aarm_stream_if.source m_out
);

  localparam int N = SINCOS_STEPS;

  logic en;
  logic                              v   [N+1];
  logic signed [aarm_pkg::CordW-1:0] cx  [N+1];
  logic signed [aarm_pkg::CordW-1:0] cy  [N+1];
  logic signed [aarm_pkg::AngW-1:0]  cz  [N+1];
  aarm_pkg::side_t                   sd  [N+1];
  aarm_pkg::in_beat_t                ib;
  aarm_pkg::out_beat_t               res;
  logic                              out_valid;

  logic signed [16:0] a_fold;
  logic               flip;

  assign ib = s_in.data;
  assign en = !out_valid || m_out.ready;
  assign s_in.ready = en;

  // Fold the angle into [-1/4, 1/4) turn
  always_comb begin
    flip = 1'b0;
    if (ib.turn_angle >= 16'd16384 && ib.turn_angle < 16'd49152) begin
      a_fold = $signed({1'b0, ib.turn_angle}) - 17'sd32768;
      flip   = 1'b1;
    end else if (ib.turn_angle >= 16'd49152) begin
      a_fold = $signed({1'b0, ib.turn_angle}) - 17'sd65536;
    end else begin
      a_fold = $signed({1'b0, ib.turn_angle});
    end
  end

  // Register the folded beat at the head of the chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= s_in.valid;
    end
    if (en) begin
      cx[0] <= aarm_pkg::CordicGain;
      cy[0] <= '0;
      cz[0] <= aarm_pkg::AngW'(a_fold) <<< 16;
      sd[0] <= '{flip: flip, ax: ib.axis_x, ay: ib.axis_y, az: ib.axis_z};
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    aarm_cordic_cell #(.STEP(i)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(v[i]), .in_x(cx[i]), .in_y(cy[i]), .in_z(cz[i]), .in_side(sd[i]),
      .out_valid(v[i+1]), .x(cx[i+1]), .y(cy[i+1]), .z(cz[i+1]), .side(sd[i+1])
    );
  end

  aarm_matrix_stage u_mat (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v[N]), .in_x(cx[N]), .in_y(cy[N]), .in_side(sd[N]),
    .out_valid(out_valid), .result(res)
  );

  assign m_out.valid = out_valid;
  assign m_out.data  = res;

  // A stalled result must hold
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !m_out.ready |=> out_valid && $stable(res))
    else $error("result changed while stalled");
  // Input is taken whenever the output is free
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> s_in.ready)
    else $error("input blocked with empty output");
  // Head of chain follows an accepted beat
  a_head: assert property (@(posedge clk) disable iff (rst)
    s_in.valid && s_in.ready |=> v[0])
    else $error("accepted beat lost");

endmodule
